// ----- rtl/core/dabc_pkg.sv -----
// Shared types, constants and the arctangent table of the Dubins arc box collision block.
package dabc_pkg;

    // Angle constants in Q16 radians, held in the 21-bit signed angle format.
    localparam logic signed [20:0] PI_Q16      = 21'sd205887;
    localparam logic signed [20:0] HALF_PI_Q16 = 21'sd102944;
    localparam logic signed [20:0] TWO_PI_Q16  = 21'sd411775;

    // Rotation steps and the start length that cancels the rotator gain (Q2.30).
    localparam int unsigned        CORDIC_STEPS = 17;
    localparam logic signed [62:0] CORDIC_GAIN  = 63'sd652032874;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_BOX_MIN_X = 2'd0,
        REG_BOX_MIN_Y = 2'd1,
        REG_BOX_MAX_X = 2'd2,
        REG_BOX_MAX_Y = 2'd3
    } t_reg_idx;

    // Modes of the shared rotator.
    typedef enum logic {
        CM_ROT = 1'b0,
        CM_VEC = 1'b1
    } t_cmode;

    // Rotator sequencer states.
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_NORM,
        CS_ITER,
        CS_POST,
        CS_DONE
    } t_cstate;

    // Main sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIV,
        ST_ROT_GO,
        ST_ROT_WAIT,
        ST_MUL_X,
        ST_MUL_Y,
        ST_SQ_HX,
        ST_SQ_HY,
        ST_SQRT_PR_GO,
        ST_SQRT_PR_WAIT,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQRT_D_GO,
        ST_SQRT_D_WAIT,
        ST_ANG_GO,
        ST_ANG_WAIT,
        ST_DECIDE,
        ST_OUT
    } t_state;

    // Request to the rotator.
    typedef struct packed {
        logic               start;
        t_cmode             mode;
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [20:0] z;
    } t_cordic_req;

    // Response of the rotator.
    typedef struct packed {
        logic               done;
        logic signed [62:0] x;
        logic signed [62:0] y;
        logic signed [20:0] z;
    } t_cordic_rsp;

    // Arctangent of 2^-i in Q16 radians.
    function automatic logic [15:0] atan_q16(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30386;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/dabc_isqrt.sv -----
// Bit-serial integer square root of a 64-bit value; a new start restarts it even while busy.
module dabc_isqrt
    import dabc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_cnt, n_cnt;
    logic [63:0] r_v, n_v;
    logic [63:0] r_res, n_res;
    logic [63:0] r_bit, n_bit;
    logic [63:0] trial;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    // One restoring step per cycle over 32 result bits.
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_v    = r_v;
        n_res  = r_res;
        n_bit  = r_bit;
        trial  = r_res + r_bit;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_v    = i_value;
            n_res  = '0;
            n_bit  = 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_v >= trial) begin
                n_v   = r_v - trial;
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[31:0];

endmodule

// ----- rtl/core/dabc_cordic.sv -----
// Shared shift-and-add rotator: sine and cosine in rotation mode, vector angle in vectoring mode.
module dabc_cordic
    import dabc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);

    t_cstate            r_state, n_state;
    t_cmode             r_mode, n_mode;
    logic [4:0]         r_cnt, n_cnt;
    logic               r_neg, n_neg;
    logic signed [62:0] r_x, n_x;
    logic signed [62:0] r_y, n_y;
    logic signed [20:0] r_z, n_z;
    logic [57:0]        r_m, n_m;

    logic signed [62:0] dx, dy, x2, y2;
    logic signed [62:0] ix, iy;
    logic signed [33:0] ax, ay;
    logic signed [20:0] zin, at, zw;
    logic [5:0]         sh;
    logic [6:0]         lim;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_neg  <= n_neg;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_m    <= n_m;
    end

    // Sequencer and the shared shift, add and compare datapath.
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_m     = r_m;

        ix  = 63'(i_req.x);
        iy  = 63'(i_req.y);
        ax  = i_req.x[32] ? -34'(i_req.x) : 34'(i_req.x);
        ay  = i_req.y[32] ? -34'(i_req.y) : 34'(i_req.y);
        zin = i_req.z;
        sh  = 6'd32 >> r_cnt[2:0];
        lim = 7'd58 - {1'b0, sh};
        dx  = r_x >>> r_cnt;
        dy  = r_y >>> r_cnt;
        x2  = r_x <<< 1;
        y2  = r_y <<< 1;
        at  = 21'($unsigned(atan_q16(r_cnt)));
        zw  = r_z;

        case (r_state)
            CS_IDLE: begin
                if (i_req.start) begin
                    n_mode = i_req.mode;
                    n_cnt  = '0;
                    n_neg  = 1'b0;
                    if (i_req.mode == CM_ROT) begin
                        // Fold the angle into the half plane the rotator covers.
                        n_x = CORDIC_GAIN;
                        n_y = '0;
                        n_z = zin;
                        if (zin > HALF_PI_Q16) begin
                            n_z   = zin - PI_Q16;
                            n_neg = 1'b1;
                        end else if (zin < -HALF_PI_Q16) begin
                            n_z   = zin + PI_Q16;
                            n_neg = 1'b1;
                        end
                        n_state = CS_ITER;
                    end else begin
                        n_x = ix;
                        n_y = iy;
                        n_z = '0;
                        n_m = (ax > ay) ? 58'(ax) : 58'(ay);
                        // A zero vector has angle zero.
                        if (i_req.x == '0 && i_req.y == '0) begin
                            n_state = CS_DONE;
                        end else begin
                            n_state = CS_NORM;
                        end
                    end
                end
            end
            CS_NORM: begin
                if (r_cnt != 5'd6) begin
                    // Binary search for the shift that lifts the larger magnitude to 2^58.
                    if ((r_m >> lim) == '0) begin
                        n_m = r_m << sh;
                        n_x = r_x <<< sh;
                        n_y = r_y <<< sh;
                    end
                    n_cnt = r_cnt + 5'd1;
                end else begin
                    // Last doubling, then turn the left half plane by a quarter turn.
                    n_x = x2;
                    n_y = y2;
                    if (x2 < 0) begin
                        if (y2 >= 0) begin
                            n_x = y2;
                            n_y = -x2;
                            n_z = HALF_PI_Q16;
                        end else begin
                            n_x = -y2;
                            n_y = x2;
                            n_z = -HALF_PI_Q16;
                        end
                    end
                    n_cnt   = '0;
                    n_state = CS_ITER;
                end
            end
            CS_ITER: begin
                if (r_mode == CM_ROT) begin
                    if (r_z >= 0) begin
                        n_x = r_x - dy;
                        n_y = r_y + dx;
                        n_z = r_z - at;
                    end else begin
                        n_x = r_x + dy;
                        n_y = r_y - dx;
                        n_z = r_z + at;
                    end
                end else begin
                    if (r_y > 0) begin
                        n_x = r_x + dy;
                        n_y = r_y - dx;
                        n_z = r_z + at;
                    end else begin
                        n_x = r_x - dy;
                        n_y = r_y + dx;
                        n_z = r_z - at;
                    end
                end
                if (r_cnt == 5'(CORDIC_STEPS - 1)) begin
                    n_state = CS_POST;
                end else begin
                    n_cnt = r_cnt + 5'd1;
                end
            end
            CS_POST: begin
                if (r_mode == CM_ROT) begin
                    if (r_neg) begin
                        n_x = -r_x;
                        n_y = -r_y;
                    end
                end else begin
                    // Map the angle into zero up to a full turn.
                    if (zw < 0) zw = zw + TWO_PI_Q16;
                    if (zw >= TWO_PI_Q16) zw = zw - TWO_PI_Q16;
                    if (zw < 0) zw = zw + TWO_PI_Q16;
                    if (zw >= TWO_PI_Q16) zw = zw - TWO_PI_Q16;
                    n_z = zw;
                end
                n_state = CS_DONE;
            end
            CS_DONE: begin
                n_state = CS_IDLE;
            end
            default: begin
                n_state = CS_IDLE;
            end
        endcase
    end

    assign o_rsp.done = (r_state == CS_DONE);
    assign o_rsp.x    = r_x;
    assign o_rsp.y    = r_y;
    assign o_rsp.z    = r_z;

endmodule

// ----- rtl/core/dubins_arc_box_collision_top.sv -----
// Top level of the Dubins arc versus obstacle box collision checker.
//
// The slave stream takes one arc per request: tdata holds start_x, start_y,
// start_heading, curvature, end_x and end_y, tlast carries last_of_curve. The
// master stream returns one result per arc: tdata holds arc_hit and curve_hit,
// tlast echoes last_of_curve and marks curve_hit as final. The block leaves it
// to the user to write the box bounds over the APB port while no arc is in flight.
//
// One arc is worked at a time; s_axis_tready is high only while idle. A
// straight segment (zero curvature) offers its result in the cycle after the
// request. A curved arc passes through a 33-step reciprocal divider, one
// rotator pass for sine and cosine, six products on one multiplier, two
// 32-step square roots and three vectoring passes of the same rotator, plus
// one decision state. An arc rejected by the circle test skips the passes
// and the decision. The result is held until the receiver takes it; the
// next arc is taken from the cycle after that. Reset clears the box bounds
// and the running curve hit.
module dubins_arc_box_collision_top
    import dabc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Arc requests.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // start_x[31:0], start_y[63:32], start_heading[82:64], curvature[114:83],
    // end_x[146:115], end_y[178:147], zero fill [183:179]
    input  logic [183:0] s_axis_tdata,
    // last_of_curve
    input  logic         s_axis_tlast,
    // Results.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // arc_hit[0], curve_hit[1], zero fill [7:2]
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_state              r_state, n_state;

    logic signed [31:0]  r_bminx, r_bminy, r_bmaxx, r_bmaxy;
    logic                r_hsf;
    logic                r_hit;
    logic                r_last;
    logic signed [31:0]  r_sx, r_sy, r_k, r_ex, r_ey;
    logic signed [18:0]  r_th;
    logic [32:0]         r_rem, r_q;
    logic [5:0]          r_cnt;
    logic [30:0]         r_r;
    logic signed [33:0]  r_cos, r_sin;
    logic signed [31:0]  r_cx, r_cy;
    logic signed [69:0]  r_prod;
    logic [63:0]         r_sqa;
    logic [31:0]         r_pr;
    logic [20:0]         r_ts, r_tf, r_tt;
    logic [1:0]          r_idx;

    t_cordic_req         creq;
    t_cordic_rsp         crsp;
    logic                sq_start, sq_done;
    logic [63:0]         sq_value;
    logic [31:0]         sq_root;

    logic                accept, wr_en, pos;
    logic [31:0]         ak;
    logic [32:0]         dtrial;
    logic                qbit;
    logic signed [32:0]  hx, hy, bcx, bcy;
    logic signed [33:0]  ddx, ddy, ox, oy;
    logic [33:0]         ahx, ahy, addx, addy;
    logic signed [34:0]  mul_a, mul_b;
    logic [64:0]         sq_sum;
    logic signed [20:0]  th_w;
    logic signed [31:0]  in_sx, in_sy, in_ex, in_ey, in_k;
    logic signed [31:0]  xmax, xmin, ymax, ymin;
    logic                seg_hit, in_box, ang_hit;

    // Saturate a sum to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
        logic signed [31:0] res;
        if (v > 41'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -41'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Configuration port.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bminx <= '0;
            r_bminy <= '0;
            r_bmaxx <= '0;
            r_bmaxy <= '0;
        end else if (wr_en) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_BOX_MIN_X: r_bminx <= pwdata;
                REG_BOX_MIN_Y: r_bminy <= pwdata;
                REG_BOX_MAX_X: r_bmaxx <= pwdata;
                REG_BOX_MAX_Y: r_bmaxy <= pwdata;
                default:       r_bminx <= r_bminx;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_BOX_MIN_X: prdata = r_bminx;
            REG_BOX_MIN_Y: prdata = r_bminy;
            REG_BOX_MAX_X: prdata = r_bmaxx;
            REG_BOX_MAX_Y: prdata = r_bmaxy;
            default:       prdata = '0;
        endcase
    end

    // Input field unpacking and the straight segment extent test.
    assign in_sx = s_axis_tdata[31:0];
    assign in_sy = s_axis_tdata[63:32];
    assign in_k  = s_axis_tdata[114:83];
    assign in_ex = s_axis_tdata[146:115];
    assign in_ey = s_axis_tdata[178:147];

    assign xmax    = (in_sx >= in_ex) ? in_sx : in_ex;
    assign xmin    = (in_sx >= in_ex) ? in_ex : in_sx;
    assign ymax    = (in_sy >= in_ey) ? in_sy : in_ey;
    assign ymin    = (in_sy >= in_ey) ? in_ey : in_sy;
    assign seg_hit = !(xmax < r_bminx || xmin > r_bmaxx || ymax < r_bminy || ymin > r_bmaxy);

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);

    // Box geometry and distances to the turning circle centre.
    assign hx   = 33'(r_bmaxx) - 33'(r_bminx);
    assign hy   = 33'(r_bmaxy) - 33'(r_bminy);
    assign bcx  = 33'(r_bminx) + (hx >>> 1);
    assign bcy  = 33'(r_bminy) + (hy >>> 1);
    assign ddx  = 34'(bcx) - 34'(r_cx);
    assign ddy  = 34'(bcy) - 34'(r_cy);
    assign ahx  = hx[32] ? -34'(hx) : 34'(hx);
    assign ahy  = hy[32] ? -34'(hy) : 34'(hy);
    assign addx = ddx[33] ? -ddx : ddx;
    assign addy = ddy[33] ? -ddy : ddy;

    // Turn direction and the centre offset direction.
    assign pos = !r_k[31];
    assign ox  = pos ? -r_sin : r_sin;
    assign oy  = pos ? r_cos : -r_cos;

    // Heading wrapped once into minus pi up to pi.
    always_comb begin
        th_w = 21'(r_th);
        if (th_w > PI_Q16) begin
            th_w = th_w - TWO_PI_Q16;
        end else if (th_w < -PI_Q16) begin
            th_w = th_w + TWO_PI_Q16;
        end
    end

    // Reciprocal step: restoring division of 2^32 by the curvature magnitude.
    assign ak     = r_k[31] ? 32'(-r_k) : 32'(r_k);
    assign dtrial = {r_rem[31:0], (r_cnt == 6'd0)};
    assign qbit   = (dtrial >= {1'b0, ak});

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MUL_X: begin
                mul_a = 35'({4'b0, r_r});
                mul_b = 35'(ox);
            end
            ST_MUL_Y: begin
                mul_a = 35'({4'b0, r_r});
                mul_b = 35'(oy);
            end
            ST_SQ_HX: begin
                mul_a = {1'b0, ahx};
                mul_b = {1'b0, ahx};
            end
            ST_SQ_HY: begin
                mul_a = {1'b0, ahy};
                mul_b = {1'b0, ahy};
            end
            ST_SQ_DX: begin
                mul_a = {1'b0, addx};
                mul_b = {1'b0, addx};
            end
            ST_SQ_DY: begin
                mul_a = {1'b0, addy};
                mul_b = {1'b0, addy};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Saturating sum of two squares.
    assign sq_sum   = {1'b0, r_sqa} + {1'b0, r_prod[63:0]};
    assign sq_value = sq_sum[64] ? '1 : sq_sum[63:0];
    assign sq_start = (r_state == ST_SQRT_PR_GO) || (r_state == ST_SQRT_D_GO);

    dabc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // Rotator request: sine and cosine of the heading, or one of three angles.
    always_comb begin
        creq.start = (r_state == ST_ROT_GO) || (r_state == ST_ANG_GO);
        creq.mode  = (r_state == ST_ROT_GO) ? CM_ROT : CM_VEC;
        creq.z     = th_w;
        case (r_idx)
            2'd0: begin
                creq.x = 33'(r_sx) - 33'(r_cx);
                creq.y = 33'(r_sy) - 33'(r_cy);
            end
            2'd1: begin
                creq.x = 33'(r_ex) - 33'(r_cx);
                creq.y = 33'(r_ey) - 33'(r_cy);
            end
            default: begin
                creq.x = ddx[32:0];
                creq.y = ddy[32:0];
            end
        endcase
    end

    dabc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (creq),
        .o_rsp   (crsp)
    );

    // Swept span test and the start point fallback.
    assign in_box = (r_sx >= r_bminx) && (r_sx <= r_bmaxx) &&
                    (r_sy >= r_bminy) && (r_sy <= r_bmaxy);

    always_comb begin
        if (pos) begin
            ang_hit = (r_tf >= r_ts && r_tt >= r_ts && r_tt <= r_tf) ||
                      (r_tf < r_ts && (r_ts <= r_tt || r_tt <= r_tf));
        end else begin
            ang_hit = (r_tf >= r_ts && (r_tt <= r_ts || r_tt >= r_tf)) ||
                      (r_ts > r_tf && r_tf <= r_tt && r_tt <= r_ts);
        end
    end

    // Sequencer state register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_hsf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) begin
                r_hsf <= r_last ? 1'b0 : (r_hsf | r_hit);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (in_k == '0) ? ST_OUT : ST_DIV;
                end
            end
            ST_DIV:          if (r_cnt == 6'd32) n_state = ST_ROT_GO;
            ST_ROT_GO:       n_state = ST_ROT_WAIT;
            ST_ROT_WAIT:     if (crsp.done) n_state = ST_MUL_X;
            ST_MUL_X:        n_state = ST_MUL_Y;
            ST_MUL_Y:        n_state = ST_SQ_HX;
            ST_SQ_HX:        n_state = ST_SQ_HY;
            ST_SQ_HY:        n_state = ST_SQRT_PR_GO;
            ST_SQRT_PR_GO:   n_state = ST_SQRT_PR_WAIT;
            ST_SQRT_PR_WAIT: if (sq_done) n_state = ST_SQ_DX;
            ST_SQ_DX:        n_state = ST_SQ_DY;
            ST_SQ_DY:        n_state = ST_SQRT_D_GO;
            ST_SQRT_D_GO:    n_state = ST_SQRT_D_WAIT;
            ST_SQRT_D_WAIT: begin
                if (sq_done) begin
                    // Circles apart: no hit.
                    if ({1'b0, r_pr} + {2'b0, r_r} < {1'b0, sq_root}) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_ANG_GO;
                    end
                end
            end
            ST_ANG_GO:       n_state = ST_ANG_WAIT;
            ST_ANG_WAIT: begin
                if (crsp.done) begin
                    n_state = (r_idx == 2'd2) ? ST_DECIDE : ST_ANG_GO;
                end
            end
            ST_DECIDE:       n_state = ST_OUT;
            ST_OUT:          if (m_axis_tready) n_state = ST_IDLE;
            default:         n_state = ST_IDLE;
        endcase
    end

    // Working registers of one arc.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_sx   <= in_sx;
                    r_sy   <= in_sy;
                    r_th   <= s_axis_tdata[82:64];
                    r_k    <= in_k;
                    r_ex   <= in_ex;
                    r_ey   <= in_ey;
                    r_last <= s_axis_tlast;
                    r_hit  <= seg_hit;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_cnt  <= '0;
                end
            end
            ST_DIV: begin
                r_rem <= qbit ? (dtrial - {1'b0, ak}) : dtrial;
                r_q   <= {r_q[31:0], qbit};
                r_cnt <= r_cnt + 6'd1;
            end
            ST_ROT_GO: begin
                r_r <= r_q[32:31] != 2'b00 ? 31'h7FFF_FFFF : r_q[30:0];
            end
            ST_ROT_WAIT: begin
                r_cos <= crsp.x[33:0];
                r_sin <= crsp.y[33:0];
            end
            ST_MUL_Y: begin
                r_cx <= sat32(41'(r_sx) + 41'(r_prod >>> 30));
            end
            ST_SQ_HX: begin
                r_cy <= sat32(41'(r_sy) + 41'(r_prod >>> 30));
            end
            ST_SQ_HY: begin
                r_sqa <= r_prod[63:0];
            end
            ST_SQRT_PR_WAIT: begin
                r_pr <= sq_root >> 1;
            end
            ST_SQ_DY: begin
                r_sqa <= r_prod[63:0];
            end
            ST_SQRT_D_WAIT: begin
                r_hit <= 1'b0;
                r_idx <= 2'd0;
            end
            ST_ANG_WAIT: begin
                if (crsp.done) begin
                    case (r_idx)
                        2'd0:    r_ts <= crsp.z;
                        2'd1:    r_tf <= crsp.z;
                        default: r_tt <= crsp.z;
                    endcase
                    r_idx <= r_idx + 2'd1;
                end
            end
            ST_DECIDE: begin
                r_hit <= ang_hit || in_box;
            end
            default: begin
                r_hit <= r_hit;
            end
        endcase
    end

    // Result channel.
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {6'b0, r_hsf | r_hit, r_hit};
    assign m_axis_tlast  = r_last;

endmodule

// ----- tb/sv/dubins_arc_box_collision_top_test.sv -----
// Self-checking testbench for the Dubins arc versus obstacle box collision checker.
module dubins_arc_box_collision_top_test
    import dabc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // One arc request as the sender builds it.
    typedef struct {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [18:0] th;
        logic signed [31:0] k;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
        logic               last;
    } t_arc;

    // One expected result.
    typedef struct {
        bit arc_hit;
        bit curve_hit;
        bit curve_done;
    } t_hit;

    // Predicts the hit flags of each accepted arc and checks the results in order.
    class t_scoreboard;
        longint  bmin_x, bmin_y, bmax_x, bmax_y;
        bit      hit_so_far;
        t_hit    hits_due[$];
        int      errors;
        longint  atan_tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                                  128, 64, 32, 16, 8, 4, 2, 1};

        function new();
            bmin_x = 0; bmin_y = 0; bmax_x = 0; bmax_y = 0;
            hit_so_far = 0;
            errors = 0;
        endfunction

        function void set_box(t_reg_idx idx, logic [31:0] v);
            longint sv;
            sv = longint'($signed(v));
            case (idx)
                REG_BOX_MIN_X: bmin_x = sv;
                REG_BOX_MIN_Y: bmin_y = sv;
                REG_BOX_MAX_X: bmax_x = sv;
                default:       bmax_y = sv;
            endcase
        endfunction

        function int pending();
            return hits_due.size();
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Sum of squares with wrapping products, saturated at the top of 64 bits.
        function longint unsigned sq_sum(longint a, longint b);
            longint unsigned ua, ub, s, t;
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            s = ua * ua;
            t = ub * ub;
            if (s > 64'hFFFF_FFFF_FFFF_FFFF - t) return 64'hFFFF_FFFF_FFFF_FFFF;
            return s + t;
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Rotation mode: cosine and sine of a Q16 angle, Q2.30 results.
        function void rotate(longint th, output longint c, output longint s);
            longint x, y, z, dx, dy;
            bit     neg;
            x = 652032874; y = 0; z = th; neg = 0;
            if (z > 102944) begin
                z -= 205887; neg = 1;
            end else if (z < -102944) begin
                z += 205887; neg = 1;
            end
            for (int i = 0; i < 17; i++) begin
                dx = x >>> i;
                dy = y >>> i;
                if (z >= 0) begin
                    x -= dy; y += dx; z -= atan_tab[i];
                end else begin
                    x += dy; y -= dx; z += atan_tab[i];
                end
            end
            c = neg ? -x : x;
            s = neg ? -y : y;
        endfunction

        // Vectoring mode: angle of a vector in Q16, mapped to [0, 2*pi).
        function longint angle(longint x, longint y);
            longint z, m, ax, ay, t, dx, dy;
            if (x == 0 && y == 0) return 0;
            z = 0;
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            m = (ax > ay) ? ax : ay;
            while (m < (longint'(1) << 58)) begin
                x *= 2; y *= 2; m *= 2;
            end
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y; y = -t; z = 102944;
                end else begin
                    x = -y; y = t; z = -102944;
                end
            end
            for (int i = 0; i < 17; i++) begin
                dx = x >>> i;
                dy = y >>> i;
                if (y > 0) begin
                    x += dy; y -= dx; z += atan_tab[i];
                end else begin
                    x -= dy; y += dx; z -= atan_tab[i];
                end
            end
            for (int i = 0; i < 2; i++) begin
                if (z < 0) z += 411775;
                if (z >= 411775) z -= 411775;
            end
            return z;
        endfunction

        function bit curved_hit(longint sx, longint sy, longint th, longint k,
                                longint ex, longint ey);
            longint unsigned ak, r, pr, d;
            longint c, s, ox, oy, cx, cy, hx, hy, bcx, bcy, ts, tf, tt;
            ak = (k < 0) ? -k : k;
            r = (64'd1 << 32) / ak;
            if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
            if (th > 205887) th -= 411775;
            else if (th < -205887) th += 411775;
            rotate(th, c, s);
            // Circle centre lies to the left of the heading for a left turn.
            if (k > 0) begin
                ox = -s; oy = c;
            end else begin
                ox = s; oy = -c;
            end
            cx = sat32(sx + ((longint'(r) * ox) >>> 30));
            cy = sat32(sy + ((longint'(r) * oy) >>> 30));
            hx = bmax_x - bmin_x;
            hy = bmax_y - bmin_y;
            bcx = bmin_x + (hx >>> 1);
            bcy = bmin_y + (hy >>> 1);
            pr = root(sq_sum(hx, hy)) >> 1;
            d = root(sq_sum(bcx - cx, bcy - cy));
            if (pr + r < d) return 0;
            ts = angle(sx - cx, sy - cy);
            tf = angle(ex - cx, ey - cy);
            tt = angle(bcx - cx, bcy - cy);
            // Swept span check, counterclockwise for a left turn.
            if (k > 0) begin
                if (tf >= ts && tt >= ts && tt <= tf) return 1;
                if (tf < ts && (ts <= tt || tt <= tf)) return 1;
            end else begin
                if (tf >= ts && (tt <= ts || tt >= tf)) return 1;
                if (ts > tf && tf <= tt && tt <= ts) return 1;
            end
            return sx >= bmin_x && sx <= bmax_x && sy >= bmin_y && sy <= bmax_y;
        endfunction

        function bit straight_hit(longint x1, longint y1, longint x2, longint y2);
            longint xmax, xmin, ymax, ymin;
            xmax = (x1 >= x2) ? x1 : x2;
            xmin = (x1 >= x2) ? x2 : x1;
            ymax = (y1 >= y2) ? y1 : y2;
            ymin = (y1 >= y2) ? y2 : y1;
            if (xmax < bmin_x || xmin > bmax_x) return 0;
            if (ymax < bmin_y || ymin > bmax_y) return 0;
            return 1;
        endfunction

        function void note_arc(t_arc a);
            t_hit h;
            if (a.k == 0) h.arc_hit = straight_hit(a.sx, a.sy, a.ex, a.ey);
            else h.arc_hit = curved_hit(a.sx, a.sy, a.th, a.k, a.ex, a.ey);
            h.curve_hit = hit_so_far | h.arc_hit;
            h.curve_done = a.last;
            hit_so_far = a.last ? 1'b0 : h.curve_hit;
            hits_due = {hits_due, h};
        endfunction

        function void check_result(logic arc_hit, logic curve_hit, logic curve_done);
            t_hit h;
            if (hits_due.size() == 0) begin
                $error("result arrived with no request outstanding");
                errors++;
                return;
            end
            h = hits_due.pop_front();
            if (arc_hit !== h.arc_hit) begin
                $error("arc_hit expected %0d got %0b", h.arc_hit, arc_hit);
                errors++;
            end
            if (curve_hit !== h.curve_hit) begin
                $error("curve_hit expected %0d got %0b", h.curve_hit, curve_hit);
                errors++;
            end
            if (curve_done !== h.curve_done) begin
                $error("curve_done expected %0d got %0b", h.curve_done, curve_done);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [183:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tlast;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    t_scoreboard   sb = new();
    bit            tx_burst;
    bit            rx_burst;

    dubins_arc_box_collision_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Clock generation.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Requests and results seen on the ports feed the scoreboard.
    always @(posedge i_clk) begin
        t_arc a;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                a.sx   = s_axis_tdata[31:0];
                a.sy   = s_axis_tdata[63:32];
                a.th   = s_axis_tdata[82:64];
                a.k    = s_axis_tdata[114:83];
                a.ex   = s_axis_tdata[146:115];
                a.ey   = s_axis_tdata[178:147];
                a.last = s_axis_tlast;
                sb.note_arc(a);
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[0], m_axis_tdata[1], m_axis_tlast);
        end
    end

    // Result receiver with random stalls and one long hold-off.
    initial begin
        int stall;
        int taken;
        taken = 0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == 400) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(posedge i_clk);
            end else begin
                stall = rx_burst ? 0 : $urandom_range(0, 14);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            taken++;
            if (taken % 100 == 0) rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    // Run time limit.
    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_arc make_arc(longint sx, longint sy, longint th, longint k,
                                      longint ex, longint ey, bit last);
        t_arc a;
        a.sx = 32'(sx); a.sy = 32'(sy); a.th = 19'(th); a.k = 32'(k);
        a.ex = 32'(ex); a.ey = 32'(ey); a.last = last;
        return a;
    endfunction

    // A coordinate near c, at most span away, clamped to 32 bits.
    function automatic longint near(longint c, longint span);
        longint v;
        v = c + longint'($urandom_range(0, (2 * span > 64'sh FFFF_FFFF) ?
                                            32'hFFFF_FFFF : 32'(2 * span))) - span;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v;
    endfunction

    task automatic send_arc(t_arc a);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, a.ey, a.ex, a.k, a.th, a.sy, a.sx};
        s_axis_tlast  <= a.last;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic apb_write(t_reg_idx idx, logic [31:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_box(idx, v);
    endtask

    // Drain every outstanding request, then load a new box.
    task automatic set_box(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                           logic [31:0] y1);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        apb_write(REG_BOX_MIN_X, x0);
        apb_write(REG_BOX_MIN_Y, y0);
        apb_write(REG_BOX_MAX_X, x1);
        apb_write(REG_BOX_MAX_Y, y1);
    endtask

    // Random arcs aimed around the box, with some fully random noise.
    task automatic random_phase(int count, longint ctr_x, longint ctr_y, longint scale);
        t_arc   a;
        longint rad, k;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                a = make_arc(longint'($signed($urandom)), longint'($signed($urandom)),
                             longint'($signed(19'($urandom))),
                             longint'($signed($urandom)), longint'($signed($urandom)),
                             longint'($signed($urandom)), $urandom_range(0, 1));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    k = 0;
                end else begin
                    rad = near(scale, scale - scale / 8);
                    if (rad < 1) rad = 1;
                    k = (longint'(1) << 32) / rad;
                    if (k > 64'sd2147483647) k = 64'sd2147483647;
                    if ($urandom_range(0, 1)) k = -k;
                end
                a = make_arc(near(ctr_x, 2 * scale), near(ctr_y, 2 * scale),
                             longint'($urandom_range(0, 411774)) - 205887, k,
                             near(ctr_x, 2 * scale), near(ctr_y, 2 * scale),
                             $urandom_range(0, 2) == 0);
            end
            send_arc(a);
        end
    endtask

    // Main sequence.
    initial begin
        longint cx, cy, sc;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_burst      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed arcs against the reset box, then a small box around the origin.
        send_arc(make_arc(0, 0, 0, 0, 0, 0, 1));
        set_box(-32'sh20000, -32'sh10000, 32'sh30000, 32'sh20000);
        send_arc(make_arc(-32'sh50000, 0, 0, 0, 32'sh50000, 0, 0));
        send_arc(make_arc(-32'sh50000, 32'sh50000, 0, 0, 32'sh50000, 32'sh50000, 1));
        send_arc(make_arc(-64'sd2147483648, -64'sd2147483648, 0, 0,
                          -64'sd2147483648, -64'sd2147483648, 0));
        send_arc(make_arc(64'sd2147483647, 64'sd2147483647, 0, 0,
                          64'sd2147483647, 64'sd2147483647, 1));
        send_arc(make_arc(0, -32'sh18000, 0, 32'sh10000, 0, 32'sh8000, 0));
        send_arc(make_arc(0, 32'sh40000, 0, -32'sh10000, 32'sh10000, 32'sh30000, 1));
        send_arc(make_arc(32'sh100000, 0, 102944, 1, 0, 0, 0));
        send_arc(make_arc(-32'sh100000, 0, -102944, -1, 0, 0, 1));
        send_arc(make_arc(32'sh8000, 0, 0, -64'sd2147483648, 32'sh8000, 2, 0));
        send_arc(make_arc(32'sh8000, 0, 0, 64'sd2147483647, 32'sh8000, 1, 1));
        send_arc(make_arc(32'sh40000, 0, 262143, 32'sh8000, 32'sh40000, 32'sh10000, 0));
        send_arc(make_arc(32'sh40000, 0, -262144, -32'sh8000, 0, 32'sh40000, 1));
        send_arc(make_arc(0, 32'sh30000, 205887, 32'sh10000, 0, -32'sh30000, 0));
        send_arc(make_arc(0, 32'sh30000, -205887, -32'sh10000, 32'sh20000, 0, 1));
        send_arc(make_arc(-64'sd2147483648, -64'sd2147483648, 51472, 32'sh100,
                          64'sd2147483647, 64'sd2147483647, 0));
        send_arc(make_arc(64'sd2147483647, -64'sd2147483648, -51472, -32'sh100,
                          -64'sd2147483648, 64'sd2147483647, 1));
        send_arc(make_arc(0, 0, 30000, 32'sh200, 32'sh900000, 32'sh900000, 0));
        send_arc(make_arc(32'sh500000, 32'sh500000, 0, 32'sh1000, 0, 0, 0));
        send_arc(make_arc(32'sh500000, 32'sh500000, 0, 0, 32'sh600000, 32'sh600000, 1));

        // Full range box: the squared sums saturate.
        set_box(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_arc(make_arc(64'sd2147483647, 64'sd2147483647, 0, 1,
                          -64'sd2147483648, -64'sd2147483648, 1));
        random_phase(200, -1, -1, 64'sd1 << 30);

        // Moderate boxes with random placement and size.
        for (int p = 0; p < 6; p++) begin
            sc = longint'($urandom_range(1 << 14, 1 << 22));
            cx = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
            cy = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
            set_box(32'(cx - sc), 32'(cy - sc / 2), 32'(cx + sc), 32'(cy + sc / 2));
            tx_burst = (p == 2);
            random_phase(190, cx, cy, sc);
        end
        tx_burst = 1'b0;

        // Inverted box: nothing lies inside it.
        set_box(32'sh30000, 32'sh20000, -32'sh20000, -32'sh10000);
        random_phase(150, 0, 0, 32'sh40000);

        // Box in the far corner of the coordinate range.
        set_box(32'h8000_0000, 32'h8000_0000, 32'h8001_0000, 32'h8001_0000);
        random_phase(100, -64'sd2147483648 + 32'sh8000, -64'sd2147483648 + 32'sh8000,
                     32'sh20000);

        // Degenerate box at the origin.
        set_box(0, 0, 0, 0);
        random_phase(100, 0, 0, 32'sh10000);

        // Let the last results drain.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
